### design/assert_macros.svh
// assertion helpers included by the rtl top
// clock and reset names follow the house convention
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// types and constants of the elevator scan controller
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int FLOOR_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int RIDER_W  = 8;
    localparam int COST_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FLOOR = 2'd2;

    // register values after reset
    localparam logic [COUNT_W-1:0] RST_FLOOR_COUNT = 7'd64;
    localparam logic [RIDER_W-1:0] RST_CAPACITY    = 8'd8;
    localparam logic [FLOOR_W-1:0] RST_START_FLOOR = 6'd0;

    typedef enum logic [1:0] {
        MOT_IDLE = 2'd0,
        MOT_UP   = 2'd1,
        MOT_DOWN = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_BOARD = 2'd1,
        REQ_DEST  = 2'd2,
        REQ_COST  = 2'd3
    } t_req;

    function automatic logic [FLOOR_W-1:0] abs_diff(input logic [FLOOR_W-1:0] a,
                                                    input logic [FLOOR_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### design/elevator_scan_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_scan_controller_top
// one elevator car scheduled by a scan rule, one result word per request word
// ----------------------------------------------------------------------------
// usage
//   request channel: i_in_valid / o_in_ready carry i_req_type and i_floor_arg
//   (tick, boarding with destination, destination only, cost query)
//   result channel: o_out_valid / i_out_ready carry the car floor, motion,
//   rider count, call cost, full flag and stop flag after that request
//   config port: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
//   (0 floor count, 1 capacity, 2 start floor); write only while idle
//   an accepted word enters the input register, then its result the result register
//   throughput: one word per cycle while the result slot drains, set by the state update
//   (priority encoders over the stop maps plus small adders)
//   a word waits in the input register while the result register is stalled,
//   so one more word is taken before o_in_ready drops
//   reset: floor count 64, capacity 8, start floor 0, car idle at floor 0,
//   stop maps and rider count cleared, both channels empty
// ----------------------------------------------------------------------------
module elevator_scan_controller_top #(
    parameter int MAX_FLOORS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [esc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [esc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_req_type,
    input  logic [esc_pkg::FLOOR_W-1:0]      i_floor_arg,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [esc_pkg::FLOOR_W-1:0]      o_floor_now,
    output logic [1:0]                       o_motion,
    output logic [esc_pkg::RIDER_W-1:0]      o_occupants,
    output logic [esc_pkg::COST_W-1:0]       o_call_cost,
    output logic                             o_car_full,
    output logic                             o_stop_reached
);
    import esc_pkg::*;
`include "assert_macros.svh"

    localparam int IDX_W = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam logic [COUNT_W-1:0]    MaxFloorsC = COUNT_W'(MAX_FLOORS);
    localparam logic [MAX_FLOORS-1:0] OneHot0   = MAX_FLOORS'(1);

    // first set bit from the bottom
    function automatic logic [IDX_W-1:0] lowest_idx(input logic [MAX_FLOORS-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_FLOORS - 1; i >= 0; i--) begin
            if (m[i]) idx = IDX_W'(i);
        end
        return idx;
    endfunction

    // first set bit from the top
    function automatic logic [IDX_W-1:0] highest_idx(input logic [MAX_FLOORS-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_FLOORS; i++) begin
            if (m[i]) idx = IDX_W'(i);
        end
        return idx;
    endfunction

    // config registers
    logic [COUNT_W-1:0]    r_floor_count;
    logic [RIDER_W-1:0]    r_capacity;
    logic [FLOOR_W-1:0]    r_start_floor;

    // car state
    logic [FLOOR_W-1:0]    r_floor,  n_floor;
    t_motion               r_motion, n_motion;
    logic [MAX_FLOORS-1:0] r_up,     n_up;
    logic [MAX_FLOORS-1:0] r_dn,     n_dn;
    logic [RIDER_W-1:0]    r_riders, n_riders;

    // input register
    logic                  r_in_valid;
    logic [1:0]            r_in_type;
    logic [FLOOR_W-1:0]    r_in_arg;

    // result register
    logic                  r_out_valid;
    logic [FLOOR_W-1:0]    r_out_floor;
    logic [1:0]            r_out_motion;
    logic [RIDER_W-1:0]    r_out_riders;
    logic [COST_W-1:0]     r_out_cost;
    logic                  r_out_full;
    logic                  r_out_reached;

    logic                  move;
    logic [COST_W-1:0]     cost;
    logic                  full;
    logic                  reached;

    // scan helpers
    logic                  up_any, dn_any, has_room, dest_ok;
    logic [COUNT_W-1:0]    limit;
    logic [MAX_FLOORS-1:0] dest_bit;
    logic [FLOOR_W-1:0]    up_lo, up_hi, dn_lo, dn_hi;
    logic [FLOOR_W-1:0]    floor_inc, floor_dec;
    logic [MAX_FLOORS-1:0] up_left, dn_left;
    t_motion               eff_motion;

    // a word moves from the input register to the result register when the
    // result slot is empty or being drained
    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;

    assign up_any   = |r_up;
    assign dn_any   = |r_dn;
    assign has_room = r_riders < r_capacity;

    assign up_lo = FLOOR_W'(lowest_idx(r_up));
    assign up_hi = FLOOR_W'(highest_idx(r_up));
    assign dn_lo = FLOOR_W'(lowest_idx(r_dn));
    assign dn_hi = FLOOR_W'(highest_idx(r_dn));

    assign floor_inc = r_floor + 1'b1;
    assign floor_dec = r_floor - 1'b1;
    assign up_left   = r_up & ~(OneHot0 << up_lo[IDX_W-1:0]);
    assign dn_left   = r_dn & ~(OneHot0 << dn_hi[IDX_W-1:0]);

    // destination check against the smaller of floor count and map size
    assign limit    = (r_floor_count < MaxFloorsC) ? r_floor_count : MaxFloorsC;
    assign dest_ok  = (COUNT_W'(r_in_arg) < limit) && (r_in_arg != r_floor);
    assign dest_bit = OneHot0 << r_in_arg[IDX_W-1:0];

    assign eff_motion = (r_motion == MOT_IDLE) ? (up_any ? MOT_UP : MOT_DOWN) : r_motion;

    always_comb begin
        n_floor  = r_floor;
        n_motion = r_motion;
        n_up     = r_up;
        n_dn     = r_dn;
        n_riders = r_riders;
        cost     = '0;
        full     = 1'b0;
        reached  = 1'b0;

        case (t_req'(r_in_type))
            REQ_TICK: begin
                if (!up_any && !dn_any) begin
                    n_motion = MOT_IDLE;
                end else begin
                    n_motion = eff_motion;
                    case (eff_motion)
                        MOT_UP: begin
                            if (!up_any) begin
                                // nothing ahead, turn without moving
                                n_motion = MOT_DOWN;
                            end else begin
                                n_floor = floor_inc;
                                if (floor_inc == up_lo) begin
                                    reached  = 1'b1;
                                    n_riders = (r_riders != '0) ? r_riders - 1'b1 : r_riders;
                                    n_up     = up_left;
                                    if (up_left == '0) n_motion = dn_any ? MOT_DOWN : MOT_IDLE;
                                end
                            end
                        end
                        MOT_DOWN: begin
                            if (!dn_any) begin
                                n_motion = MOT_UP;
                            end else begin
                                n_floor = floor_dec;
                                if (floor_dec == dn_hi) begin
                                    reached  = 1'b1;
                                    n_riders = (r_riders != '0) ? r_riders - 1'b1 : r_riders;
                                    n_dn     = dn_left;
                                    if (dn_left == '0) n_motion = up_any ? MOT_UP : MOT_IDLE;
                                end
                            end
                        end
                        default: begin
                            // undefined motion code: tick leaves everything
                            n_motion = r_motion;
                        end
                    endcase
                end
            end
            REQ_BOARD: begin
                if (has_room) begin
                    n_riders = r_riders + 1'b1;
                    if (dest_ok && (r_in_arg > r_floor)) n_up = r_up | dest_bit;
                    if (dest_ok && (r_in_arg < r_floor)) n_dn = r_dn | dest_bit;
                end else begin
                    full = 1'b1;
                end
            end
            REQ_DEST: begin
                if (dest_ok && (r_in_arg > r_floor)) n_up = r_up | dest_bit;
                if (dest_ok && (r_in_arg < r_floor)) n_dn = r_dn | dest_bit;
            end
            REQ_COST: begin
                if (!has_room) begin
                    full = 1'b1;
                end else if (r_motion == MOT_UP && r_in_arg < r_floor && up_any) begin
                    // sweep up to the top stop, then back down to the call
                    cost = COST_W'(abs_diff(up_hi, r_floor)) + COST_W'(abs_diff(up_hi, r_in_arg));
                end else if (r_motion == MOT_DOWN && r_in_arg > r_floor && dn_any) begin
                    cost = COST_W'(abs_diff(r_floor, dn_lo)) + COST_W'(abs_diff(dn_lo, r_in_arg));
                end else begin
                    cost = COST_W'(abs_diff(r_floor, r_in_arg));
                end
            end
            default: begin
                full = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_count <= RST_FLOOR_COUNT;
            r_capacity    <= RST_CAPACITY;
            r_start_floor <= RST_START_FLOOR;
            r_floor       <= RST_START_FLOOR;
            r_motion      <= MOT_IDLE;
            r_up          <= '0;
            r_dn          <= '0;
            r_riders      <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // input register
            if (o_in_ready) r_in_valid <= i_in_valid;

            // result register
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLOOR_COUNT: r_floor_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_CAPACITY:    r_capacity    <= i_cfg_data[RIDER_W-1:0];
                    CFG_START_FLOOR: begin
                        // place the car and forget all stops, riders stay
                        r_start_floor <= i_cfg_data[FLOOR_W-1:0];
                        r_floor       <= i_cfg_data[FLOOR_W-1:0];
                        r_motion      <= MOT_IDLE;
                        r_up          <= '0;
                        r_dn          <= '0;
                    end
                    default: r_start_floor <= r_start_floor;
                endcase
            end else if (move) begin
                r_floor  <= n_floor;
                r_motion <= n_motion;
                r_up     <= n_up;
                r_dn     <= n_dn;
                r_riders <= n_riders;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_type <= i_req_type;
            r_in_arg  <= i_floor_arg;
        end
        if (move) begin
            r_out_floor   <= n_floor;
            r_out_motion  <= n_motion;
            r_out_riders  <= n_riders;
            r_out_cost    <= cost;
            r_out_full    <= full;
            r_out_reached <= reached;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_floor_now    = r_out_floor;
    assign o_motion       = r_out_motion;
    assign o_occupants    = r_out_riders;
    assign o_call_cost    = r_out_cost;
    assign o_car_full     = r_out_full;
    assign o_stop_reached = r_out_reached;

    // checks
    `ASSERT_CLK(a_idle_when_empty, move && r_in_type == REQ_TICK && !up_any && !dn_any && !i_cfg_we |=> r_motion == MOT_IDLE, "tick with no stops left car moving")
    `ASSERT_CLK(a_full_no_cost, o_out_valid && o_car_full |-> o_call_cost == '0, "full car reported a cost")
    `ASSERT_CLK(a_result_from_move, $rose(r_out_valid) |-> $past(move), "result appeared without a transfer")
    `ASSERT_ALWAYS(a_ready_blocked, !o_in_ready |-> r_in_valid && r_out_valid, "input stalled with a free slot")

endmodule

### test/elevator_scan_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_scan_controller_top_tb
// self-checking bench for the scan-scheduled elevator car
// ----------------------------------------------------------------------------
// request words go in on a valid/ready channel and every accepted word is run
// through a bit-accurate car model kept in a small scoreboard class; each
// result word is then compared field by field with the oldest prediction.
// the run walks through several register settings (extremes included): a
// short directed opener, then weighted random traffic with random gaps on
// both channels, one long output stall, one sender pause and one stretch
// with no gaps at all
// ----------------------------------------------------------------------------
module elevator_scan_controller_top_tb;
    import esc_pkg::*;

    localparam int MAX_FLOORS   = 64;
    localparam int HOLD_CYCLES  = 40;     // long output stall
    localparam int DRAIN_CYCLES = 6;      // settle time after the last result
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int MAX_REPORTS  = 10;
    localparam int NUM_PHASES   = 7;

    // register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // one result word as the block reports it
    typedef struct packed {
        logic [FLOOR_W-1:0] floor_now;
        logic [1:0]         motion;
        logic [RIDER_W-1:0] occupants;
        logic [COST_W-1:0]  call_cost;
        logic               car_full;
        logic               stop_reached;
    } t_car_report;

    // ------------------------------------------------------------------------
    // car model and expected-report store
    // ------------------------------------------------------------------------
    class car_scoreboard;
        logic [COUNT_W-1:0] floor_count;
        logic [RIDER_W-1:0] capacity;
        logic [FLOOR_W-1:0] start_floor;
        logic [FLOOR_W-1:0] car_floor;
        t_motion            car_motion;
        logic [63:0]        up_stops;
        logic [63:0]        down_stops;
        logic [RIDER_W-1:0] riders;
        t_car_report        expected_q[$];
        int                 mismatches;

        function new();
            floor_count = RST_FLOOR_COUNT;
            capacity    = RST_CAPACITY;
            start_floor = RST_START_FLOOR;
            car_floor   = RST_START_FLOOR;
            car_motion  = MOT_IDLE;
            up_stops    = '0;
            down_stops  = '0;
            riders      = '0;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int lowest_stop(logic [63:0] stops);
            for (int i = 0; i < 64; i++)
                if (stops[i]) return i;
            return 0;
        endfunction

        function int highest_stop(logic [63:0] stops);
            for (int i = 63; i >= 0; i--)
                if (stops[i]) return i;
            return 0;
        endfunction

        function int floor_gap(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FLOOR_COUNT: floor_count = data[COUNT_W-1:0];
                CFG_CAPACITY:    capacity = data;
                CFG_START_FLOOR: begin
                    // car is parked at the new floor, riders stay aboard
                    start_floor = data[FLOOR_W-1:0];
                    car_floor   = start_floor;
                    car_motion  = MOT_IDLE;
                    up_stops    = '0;
                    down_stops  = '0;
                end
                default: ;
            endcase
        endfunction

        function void add_stop(logic [FLOOR_W-1:0] dest);
            int limit;
            limit = (floor_count < MAX_FLOORS) ? int'(floor_count) : MAX_FLOORS;
            // out of range or already here: no stop
            if (dest >= limit || dest == car_floor) return;
            if (dest > car_floor) up_stops[dest] = 1'b1;
            else down_stops[dest] = 1'b1;
        endfunction

        function void drop_rider();
            if (riders != 0) riders--;
        endfunction

        // one tick of car motion, returns 1 on arrival at a stop
        function logic advance_car();
            int target;
            if (up_stops == 0 && down_stops == 0) begin
                car_motion = MOT_IDLE;
                return 1'b0;
            end
            if (car_motion == MOT_IDLE) begin
                if (up_stops != 0) car_motion = MOT_UP;
                else car_motion = MOT_DOWN;
            end
            if (car_motion == MOT_UP) begin
                // turn without moving when the up map ran dry
                if (up_stops == 0) begin
                    car_motion = MOT_DOWN;
                    return 1'b0;
                end
                target = lowest_stop(up_stops);
                car_floor = car_floor + 1'b1;
                if (car_floor == target) begin
                    drop_rider();
                    up_stops[target] = 1'b0;
                    if (up_stops == 0) begin
                        if (down_stops != 0) car_motion = MOT_DOWN;
                        else car_motion = MOT_IDLE;
                    end
                    return 1'b1;
                end
            end else if (car_motion == MOT_DOWN) begin
                if (down_stops == 0) begin
                    car_motion = MOT_UP;
                    return 1'b0;
                end
                target = highest_stop(down_stops);
                car_floor = car_floor - 1'b1;
                if (car_floor == target) begin
                    drop_rider();
                    down_stops[target] = 1'b0;
                    if (down_stops == 0) begin
                        if (up_stops != 0) car_motion = MOT_UP;
                        else car_motion = MOT_IDLE;
                    end
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // floors travelled before the car can serve an outside call
        function logic [COST_W-1:0] call_cost_to(logic [FLOOR_W-1:0] call);
            int cur, req, far, c;
            cur = car_floor;
            req = call;
            if (car_motion == MOT_UP && req < cur && up_stops != 0) begin
                far = highest_stop(up_stops);
                c = floor_gap(far, cur) + floor_gap(far, req);
            end else if (car_motion == MOT_DOWN && req > cur && down_stops != 0) begin
                far = lowest_stop(down_stops);
                c = floor_gap(cur, far) + floor_gap(far, req);
            end else begin
                c = floor_gap(cur, req);
            end
            return c[COST_W-1:0];
        endfunction

        function void note_request(t_req kind, logic [FLOOR_W-1:0] arg);
            t_car_report r;
            r = '0;
            case (kind)
                REQ_TICK: r.stop_reached = advance_car();
                REQ_BOARD: begin
                    if (riders < capacity) begin
                        add_stop(arg);
                        riders++;
                    end else begin
                        r.car_full = 1'b1;
                    end
                end
                REQ_DEST: add_stop(arg);
                REQ_COST: begin
                    if (riders < capacity) r.call_cost = call_cost_to(arg);
                    else r.car_full = 1'b1;
                end
            endcase
            r.floor_now = car_floor;
            r.motion    = car_motion;
            r.occupants = riders;
            expected_q.push_back(r);
        endfunction

        function string describe(t_car_report r);
            return $sformatf("floor %0d motion %0d riders %0d cost %0d full %0b stop %0b",
                             r.floor_now, r.motion, r.occupants, r.call_cost,
                             r.car_full, r.stop_reached);
        endfunction

        function void check_result(t_car_report got);
            t_car_report want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected: %s", $realtime,
                             describe(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.floor_now !== want.floor_now || got.motion !== want.motion ||
                got.occupants !== want.occupants || got.call_cost !== want.call_cost ||
                got.car_full !== want.car_full || got.stop_reached !== want.stop_reached) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                             describe(want), describe(got));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_req_type;
    logic [FLOOR_W-1:0]    i_floor_arg;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [FLOOR_W-1:0]    o_floor_now;
    logic [1:0]            o_motion;
    logic [RIDER_W-1:0]    o_occupants;
    logic [COST_W-1:0]     o_call_cost;
    logic                  o_car_full;
    logic                  o_stop_reached;

    elevator_scan_controller_top #(
        .MAX_FLOORS(MAX_FLOORS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_floor_arg   (i_floor_arg),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_floor_now   (o_floor_now),
        .o_motion      (o_motion),
        .o_occupants   (o_occupants),
        .o_call_cost   (o_call_cost),
        .o_car_full    (o_car_full),
        .o_stop_reached(o_stop_reached)
    );

    car_scoreboard sb;

    // gap and stall controls for the driver and the output side
    logic in_idle_on;
    logic out_idle_on;
    logic hold_req;

    // register settings per phase, phase 0 runs on the reset values
    int phase_floors[NUM_PHASES] = '{64, 2, 10, 37, 5, 64, 64};
    int phase_cap[NUM_PHASES]    = '{8, 1, 0, 3, 4, 16, 255};
    int phase_start[NUM_PHASES]  = '{0, 1, 5, 20, 40, 32, 63};
    int phase_words[NUM_PHASES]  = '{130, 150, 110, 260, 150, 300, 250};

    // directed opener on reset values: empty-map tick, cost extremes,
    // stop reached with nobody aboard, destination at the car floor,
    // cost while moving away, then fill the car until boarding is refused
    localparam int DEMO_WORDS = 24;
    t_req demo_kind[DEMO_WORDS] = '{
        REQ_TICK, REQ_COST, REQ_COST, REQ_DEST, REQ_TICK, REQ_TICK,
        REQ_BOARD, REQ_BOARD, REQ_BOARD, REQ_TICK, REQ_COST, REQ_DEST,
        REQ_TICK, REQ_TICK, REQ_TICK, REQ_COST, REQ_BOARD, REQ_BOARD,
        REQ_BOARD, REQ_BOARD, REQ_BOARD, REQ_BOARD, REQ_BOARD, REQ_COST
    };
    logic [FLOOR_W-1:0] demo_arg[DEMO_WORDS] = '{
        6'd0, 6'd0, 6'd63, 6'd2, 6'd0, 6'd0,
        6'd2, 6'd63, 6'd0, 6'd0, 6'd1, 6'd6,
        6'd0, 6'd0, 6'd0, 6'd60, 6'd10, 6'd11,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd20, 6'd0
    };

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // monitor: check the result first, then record the accepted word, so a
    // word and a result on the same edge never cross
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result('{o_floor_now, o_motion, o_occupants, o_call_cost,
                                  o_car_full, o_stop_reached});
            if (i_in_valid && o_in_ready)
                sb.note_request(t_req'(i_req_type), i_floor_arg);
        end
    end

    // ------------------------------------------------------------------------
    // output side: random back-pressure, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= !(out_idle_on && $urandom_range(99) < 17);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any word moving on either channel
    // ------------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no handshake for %0d cycles", STALL_LIMIT);
        $display("** elevator_scan_controller_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver tasks, all entered and left on a falling edge
    // ------------------------------------------------------------------------

    // offer one word and hold it until the block takes it
    task automatic send_word(input t_req kind, input logic [FLOOR_W-1:0] arg);
        while (in_idle_on && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_floor_arg <= arg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // register write, model follows once the edge has passed
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // random request kind: ticks dominate so the car actually travels
    function automatic t_req pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40) return REQ_TICK;
        if (r < 65) return REQ_BOARD;
        if (r < 80) return REQ_DEST;
        return REQ_COST;
    endfunction

    // mostly floors in use, sometimes anything the field can carry
    function automatic logic [FLOOR_W-1:0] pick_floor();
        int top;
        top = (sb.floor_count < MAX_FLOORS) ? int'(sb.floor_count) : MAX_FLOORS;
        if (top > 0 && $urandom_range(99) < 75)
            return FLOOR_W'($urandom_range(top - 1));
        return FLOOR_W'($urandom_range(63));
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_FLOOR_COUNT;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_TICK;
        i_floor_arg = '0;
        i_out_ready = 1'b0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        hold_req    = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // registers change only with nothing in flight
            if (p != 0) begin
                wait_drained();
                write_reg(CFG_FLOOR_COUNT, CFG_DATA_W'(phase_floors[p]));
                write_reg(CFG_CAPACITY, CFG_DATA_W'(phase_cap[p]));
                write_reg(CFG_START_FLOOR, CFG_DATA_W'(phase_start[p]));
                // capacity-zero phase also pokes the undecoded index
                if (phase_cap[p] == 0)
                    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(255)));
                i_cfg_we <= 1'b0;
            end

            // one phase runs without any gaps on either side
            in_idle_on  = (p != 5);
            out_idle_on = (p != 5);

            if (p == 0)
                for (int i = 0; i < DEMO_WORDS; i++)
                    send_word(demo_kind[i], demo_arg[i]);

            for (int i = 0; i < phase_words[p]; i++) begin
                // long output stall while the sender keeps pushing
                if (p == 3 && i == 60) hold_req = 1'b1;
                // sender pause until the pipe is empty
                if (p == 3 && i == 180) wait_drained();
                send_word(pick_kind(), pick_floor());
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** elevator_scan_controller_top: PASSED **");
        else
            $display("** elevator_scan_controller_top: FAILED **");
        $finish;
    end

endmodule
